### hdl/x86enc_pkg.sv
// Package for the x86 instruction byte encoder.
// Holds the form, size and address mode codes, the x86 field constants and
// the queue entry type. No dependencies.
package x86enc_pkg;

  // Instruction form.
  typedef enum logic [1:0] {
    FORM_SIMPLE = 2'd0,
    FORM_BINARY = 2'd1,
    FORM_IMM    = 2'd2,
    FORM_NONE   = 2'd3
  } form_t;

  // Operand size. The reserved code behaves as thirty-two bit.
  typedef enum logic [1:0] {
    SZ_8   = 2'd0,
    SZ_16  = 2'd1,
    SZ_32  = 2'd2,
    SZ_RSV = 2'd3
  } size_t;

  // Addressing mode.
  typedef enum logic [1:0] {
    AM_REG  = 2'd0,
    AM_PTR  = 2'd1,
    AM_SIB  = 2'd2,
    AM_NONE = 2'd3
  } amode_t;

  localparam logic [7:0] PREFIX_OPSIZE = 8'h66;
  localparam logic [7:0] IMM_GROUP_OP  = 8'h80;
  localparam logic [1:0] MOD_MEM       = 2'b00;
  localparam logic [1:0] MOD_DISP8     = 2'b01;
  localparam logic [1:0] MOD_DISP32    = 2'b10;
  localparam logic [1:0] MOD_REG       = 2'b11;
  localparam logic [2:0] RM_SIB        = 3'b100;

  localparam int unsigned MAX_BYTES = 8;

  // One encoded instruction: up to eight bytes and the index of the last one.
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [2:0]                last_idx;
  } entry_t;

endpackage

### hdl/x86enc_if.sv
// Channel interfaces for the x86 instruction byte encoder.
// x86enc_in_if carries instruction descriptions, x86enc_out_if carries bytes.
// No dependencies.
interface x86enc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [1:0]  op_size;
  logic [7:0]  opcode;
  logic        direction;
  logic [1:0]  addr_mode;
  logic [2:0]  src_reg;
  logic [2:0]  dst_reg;
  logic [1:0]  sib_scale;
  logic [2:0]  index_reg;
  logic [31:0] displacement;
  logic [31:0] imm_value;

  modport source (
    output valid, operation, op_size, opcode, direction, addr_mode, src_reg,
           dst_reg, sib_scale, index_reg, displacement, imm_value,
    input  ready
  );
  modport sink (
    input  valid, operation, op_size, opcode, direction, addr_mode, src_reg,
           dst_reg, sib_scale, index_reg, displacement, imm_value,
    output ready
  );
endinterface

interface x86enc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, out_byte, last, input ready);
  modport sink   (input valid, out_byte, last, output ready);
endinterface

### hdl/x86enc_front.sv
// Front end of the x86 instruction byte encoder: accepts an instruction
// description and assembles its byte sequence for the queue.
// Depends on x86enc_pkg and x86enc_in_if.
module x86enc_front (
  x86enc_in_if.sink          in_ch,
  input  logic               q_full,
  output logic               push,
  output x86enc_pkg::entry_t push_entry
);

  x86enc_pkg::form_t  form;
  x86enc_pkg::size_t  size;
  x86enc_pkg::amode_t mode;
  logic [x86enc_pkg::MAX_BYTES-1:0][7:0] vec;
  logic [3:0] n;
  logic       w_bit;
  logic       disp_nz;
  logic       disp_big;
  logic       imm_small;
  logic [2:0] ext;

  assign form      = x86enc_pkg::form_t'(in_ch.operation);
  assign size      = x86enc_pkg::size_t'(in_ch.op_size);
  assign mode      = x86enc_pkg::amode_t'(in_ch.addr_mode);
  assign w_bit     = (size != x86enc_pkg::SZ_8);
  assign disp_nz   = |in_ch.displacement;
  assign disp_big  = |in_ch.displacement[31:8];
  assign imm_small = ~|in_ch.imm_value[31:8];
  assign ext       = in_ch.opcode[2:0];

  // Bytes are appended in emission order; n counts those placed so far.
  always_comb begin
    vec = '0;
    n   = 4'd0;
    if (form != x86enc_pkg::FORM_NONE && size == x86enc_pkg::SZ_16) begin
      vec[n[2:0]] = x86enc_pkg::PREFIX_OPSIZE;
      n = n + 4'd1;
    end
    unique case (form)
      x86enc_pkg::FORM_SIMPLE: begin
        vec[n[2:0]] = in_ch.opcode;
        n = n + 4'd1;
      end
      x86enc_pkg::FORM_BINARY: begin
        vec[n[2:0]] = in_ch.opcode | {6'd0, in_ch.direction, w_bit};
        n = n + 4'd1;
        unique case (mode)
          x86enc_pkg::AM_REG: begin
            vec[n[2:0]] = {x86enc_pkg::MOD_REG, in_ch.src_reg, in_ch.dst_reg};
            n = n + 4'd1;
          end
          x86enc_pkg::AM_PTR: begin
            if (!disp_nz) begin
              vec[n[2:0]] = {x86enc_pkg::MOD_MEM, in_ch.src_reg, in_ch.dst_reg};
            end else if (!disp_big) begin
              vec[n[2:0]] = {x86enc_pkg::MOD_DISP8, in_ch.src_reg, in_ch.dst_reg};
            end else begin
              vec[n[2:0]] = {x86enc_pkg::MOD_DISP32, in_ch.src_reg, in_ch.dst_reg};
            end
            n = n + 4'd1;
          end
          x86enc_pkg::AM_SIB: begin
            vec[n[2:0]] = {x86enc_pkg::MOD_MEM, in_ch.src_reg, x86enc_pkg::RM_SIB};
            n = n + 4'd1;
            vec[n[2:0]] = {in_ch.sib_scale, in_ch.index_reg, in_ch.dst_reg};
            n = n + 4'd1;
          end
          x86enc_pkg::AM_NONE: begin
          end
        endcase
        if (disp_big) begin
          for (int k = 0; k < 4; k++) begin
            vec[n[2:0]] = in_ch.displacement[8*k +: 8];
            n = n + 4'd1;
          end
        end else if (disp_nz) begin
          vec[n[2:0]] = in_ch.displacement[7:0];
          n = n + 4'd1;
        end
      end
      x86enc_pkg::FORM_IMM: begin
        vec[n[2:0]] = x86enc_pkg::IMM_GROUP_OP | {6'd0, imm_small, w_bit};
        n = n + 4'd1;
        unique case (mode)
          x86enc_pkg::AM_REG: begin
            vec[n[2:0]] = {x86enc_pkg::MOD_REG, ext, in_ch.dst_reg};
            n = n + 4'd1;
          end
          x86enc_pkg::AM_SIB: begin
            vec[n[2:0]] = {x86enc_pkg::MOD_MEM, ext, x86enc_pkg::RM_SIB};
            n = n + 4'd1;
            vec[n[2:0]] = {in_ch.sib_scale, in_ch.index_reg, in_ch.dst_reg};
            n = n + 4'd1;
          end
          x86enc_pkg::AM_PTR, x86enc_pkg::AM_NONE: begin
          end
        endcase
        if (imm_small) begin
          vec[n[2:0]] = in_ch.imm_value[7:0];
          n = n + 4'd1;
        end else begin
          for (int k = 0; k < 4; k++) begin
            vec[n[2:0]] = in_ch.imm_value[8*k +: 8];
            n = n + 4'd1;
          end
        end
      end
      x86enc_pkg::FORM_NONE: begin
      end
    endcase
  end

  assign in_ch.ready         = !q_full;
  assign push                = in_ch.valid && !q_full && (form != x86enc_pkg::FORM_NONE);
  assign push_entry.bytes    = vec;
  assign push_entry.last_idx = 3'(n - 4'd1);

endmodule

### hdl/x86enc_queue.sv
// Small queue of encoded instructions between front and back end.
// Depends on x86enc_pkg.
module x86enc_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  x86enc_pkg::entry_t push_entry,
  input  logic               pop,
  output logic               full,
  output logic               not_empty,
  output x86enc_pkg::entry_t head
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  x86enc_pkg::entry_t store_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = store_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_entry;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("queue read while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count beyond depth");
`endif

endmodule

### hdl/x86enc_back.sv
// Back end of the x86 instruction byte encoder: takes encoded instructions
// from the queue and sends them out one byte per cycle while ready, with a last mark.
// Depends on x86enc_pkg and x86enc_out_if.
module x86enc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_not_empty,
  input  x86enc_pkg::entry_t q_head,
  output logic               pop,
  x86enc_out_if.source       out_ch
);

  x86enc_pkg::entry_t cur_r;
  logic               busy_r, busy_nxt;
  logic [2:0]         idx_r, idx_nxt;
  logic               at_last;
  logic               out_fire;

  assign at_last  = (idx_r == cur_r.last_idx);
  assign out_fire = busy_r && out_ch.ready;
  // Next instruction is loaded in the same cycle its predecessor's last byte leaves.
  assign pop      = q_not_empty && (!busy_r || (out_fire && at_last));

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (pop) begin
      busy_nxt = 1'b1;
      idx_nxt  = 3'd0;
    end else if (out_fire) begin
      if (at_last) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 3'd0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= q_head;
    end
  end

  assign out_ch.valid    = busy_r;
  assign out_ch.out_byte = cur_r.bytes[idx_r];
  assign out_ch.last     = at_last;

`ifndef NO_ASSERTIONS
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (idx_r <= cur_r.last_idx))
    else $error("byte index past end of instruction");

  a_idx_starts_zero: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (idx_r == 3'd0) && busy_r)
    else $error("new instruction did not start at its first byte");
`endif

endmodule

### hdl/x86_instruction_byte_encoder.sv
// x86 instruction byte encoder. Each input item describes one instruction
// (simple, binary register/memory, or immediate group form) and produces
// its machine bytes on the output channel, one byte per cycle while the
// receiver is ready, in emission order, with last set on the final byte.
// An instruction yields one to eight bytes and holds the byte serializer
// in the back end while they are sent; an item with the unused form code
// yields no bytes and takes no serializer time. The front end assembles
// the whole byte string in the cycle it accepts an item and writes it
// into a queue of QUEUE_DEPTH entries, so input is taken every cycle while
// the queue has room and the sustained input rate equals the output byte
// rate divided by bytes per instruction. An accepted item is registered
// first into the queue and then into the serializer before its first byte
// is offered. Both channels use a valid/ready handshake; out_ch holds its
// byte stable while stalled. The block keeps no state between instructions.
// Depends on x86enc_pkg, x86enc_if, x86enc_front, x86enc_queue, x86enc_back.
module x86_instruction_byte_encoder #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  x86enc_in_if.sink     in_ch,
  x86enc_out_if.source  out_ch
);

  // Front end to queue.
  logic               push;
  x86enc_pkg::entry_t push_entry;
  logic               q_full;

  // Queue to back end.
  logic               q_not_empty;
  logic               pop;
  x86enc_pkg::entry_t q_head;

  // Classification and byte assembly; input ready follows queue room only.
  x86enc_front u_front (
    .in_ch      (in_ch),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // Decouples acceptance of new items from the byte-by-byte output.
  x86enc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  // Serializer: one byte per cycle while ready; no gap when the next instruction is already queued.
  x86enc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .pop         (pop),
    .out_ch      (out_ch)
  );

endmodule

### tb/sv/x86_instruction_byte_encoder_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the x86 instruction byte encoder.
// Depends on x86enc_pkg, the x86enc_in_if / x86enc_out_if interfaces and the
// x86_instruction_byte_encoder top level.
module x86_instruction_byte_encoder_tb;

  // The run ends here even if the block hangs. The slowest correct run is
  // about 310 instructions of at most eight bytes, each byte waiting out a
  // receiver stalling three quarters of the time; this limit is many times that.
  localparam int unsigned CYCLE_LIMIT = 400000;
  // Items per random phase; four phases and the directed items give 311.
  localparam int unsigned RANDOM_PER_PHASE = 72;
  // Cycles allowed for stray bytes after the last expected byte. The block
  // registers an accepted item in the queue and then in the serializer before offering its first byte.
  localparam int unsigned DRAIN_CYCLES = 16;

  // One instruction description as the testbench sees it.
  typedef struct {
    x86enc_pkg::form_t  form;
    x86enc_pkg::size_t  size;
    logic [7:0]         opcode;
    logic               direction;
    x86enc_pkg::amode_t amode;
    logic [2:0]         src_reg;
    logic [2:0]         dst_reg;
    logic [1:0]         scale;
    logic [2:0]         index_reg;
    logic [31:0]        disp;
    logic [31:0]        imm;
  } instr_t;

  // One machine byte with its end-of-instruction flag.
  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } code_byte_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  x86enc_in_if  in_ch ();
  x86enc_out_if out_ch ();

  x86_instruction_byte_encoder u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #2 clk = ~clk;

  instr_t      pending_instrs[$];   // instructions not yet offered to the block
  instr_t      cur_instr;           // the instruction currently on the input channel
  code_byte_t  expected_bytes[$];   // machine bytes still owed by the block
  int unsigned queued_count = 0;
  int unsigned accepted_count = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  // Works out the machine bytes of one accepted instruction and appends them
  // to expected_bytes, with last set on the final one. The unused form code
  // yields nothing at all.
  task automatic predict_encoding(input instr_t d);
    logic [7:0] enc[$];
    logic [7:0] op;
    logic       short_imm;
    int         k;
    if (d.form == x86enc_pkg::FORM_NONE) return;

    // Sixteen-bit operands take the operand-size prefix in every form.
    if (d.size == x86enc_pkg::SZ_16) enc.push_back(x86enc_pkg::PREFIX_OPSIZE);

    case (d.form)
      x86enc_pkg::FORM_SIMPLE: begin
        enc.push_back(d.opcode);
      end
      x86enc_pkg::FORM_BINARY: begin
        // Bit 0 is the width bit (any size but eight), bit 1 the direction.
        op = d.opcode | {6'b0, d.direction, d.size != x86enc_pkg::SZ_8};
        enc.push_back(op);
        case (d.amode)
          x86enc_pkg::AM_REG: begin
            enc.push_back({x86enc_pkg::MOD_REG, d.src_reg, d.dst_reg});
          end
          x86enc_pkg::AM_PTR: begin
            if (d.disp == 32'd0) begin
              enc.push_back({x86enc_pkg::MOD_MEM, d.src_reg, d.dst_reg});
            end else if (d.disp <= 32'hff) begin
              enc.push_back({x86enc_pkg::MOD_DISP8, d.src_reg, d.dst_reg});
            end else begin
              enc.push_back({x86enc_pkg::MOD_DISP32, d.src_reg, d.dst_reg});
            end
          end
          x86enc_pkg::AM_SIB: begin
            enc.push_back({x86enc_pkg::MOD_MEM, d.src_reg, x86enc_pkg::RM_SIB});
            enc.push_back({d.scale, d.index_reg, d.dst_reg});
          end
          default: begin
            // The unused address mode drops ModRM and SIB but keeps the
            // displacement below.
          end
        endcase
        // A nonzero displacement follows in every address mode, one byte
        // when it fits in eight bits and four little-endian bytes otherwise.
        if (d.disp > 32'hff) begin
          for (k = 0; k < 4; k++) enc.push_back(d.disp[8*k +: 8]);
        end else if (d.disp != 32'd0) begin
          enc.push_back(d.disp[7:0]);
        end
      end
      default: begin
        // Immediate group form. The low three opcode bits go into the ModRM
        // reg field; bit 1 of the group opcode marks a one-byte immediate.
        short_imm = (d.imm <= 32'hff);
        op = x86enc_pkg::IMM_GROUP_OP | {6'b0, short_imm, d.size != x86enc_pkg::SZ_8};
        enc.push_back(op);
        case (d.amode)
          x86enc_pkg::AM_REG: begin
            enc.push_back({x86enc_pkg::MOD_REG, d.opcode[2:0], d.dst_reg});
          end
          x86enc_pkg::AM_SIB: begin
            enc.push_back({x86enc_pkg::MOD_MEM, d.opcode[2:0], x86enc_pkg::RM_SIB});
            enc.push_back({d.scale, d.index_reg, d.dst_reg});
          end
          default: begin
            // Pointer and unused modes emit no ModRM here, and the immediate
            // form never carries a displacement.
          end
        endcase
        if (short_imm) begin
          enc.push_back(d.imm[7:0]);
        end else begin
          for (k = 0; k < 4; k++) enc.push_back(d.imm[8*k +: 8]);
        end
      end
    endcase

    for (k = 0; k < enc.size(); k++) begin
      expected_bytes.push_back('{value: enc[k], last: (k == enc.size() - 1)});
    end
  endtask

  function automatic instr_t make_instr(x86enc_pkg::form_t form, x86enc_pkg::size_t size,
                                        logic [7:0] opcode, int unsigned direction,
                                        x86enc_pkg::amode_t amode, int unsigned src_reg,
                                        int unsigned dst_reg, int unsigned scale,
                                        int unsigned index_reg, logic [31:0] disp,
                                        logic [31:0] imm);
    instr_t d;
    d.form      = form;
    d.size      = size;
    d.opcode    = opcode;
    d.direction = 1'(direction);
    d.amode     = amode;
    d.src_reg   = 3'(src_reg);
    d.dst_reg   = 3'(dst_reg);
    d.scale     = 2'(scale);
    d.index_reg = 3'(index_reg);
    d.disp      = disp;
    d.imm       = imm;
    return d;
  endfunction

  // Picks a 32-bit operand from one of four classes so that zero, the
  // one-byte range, the four-byte range and the boundaries between them all
  // show up often.
  function automatic logic [31:0] pick_operand();
    logic [31:0] v;
    case ($urandom_range(3))
      0: v = 32'd0;
      1: v = $urandom_range(255, 1);
      2: begin
        v = $urandom;
        if (v <= 32'hff) v = v | 32'h100;
      end
      default: begin
        case ($urandom_range(3))
          0: v = 32'd1;
          1: v = 32'hff;
          2: v = 32'h100;
          default: v = 32'hffff_ffff;
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic instr_t random_instr();
    instr_t d;
    // The unused form code is kept rare since it produces nothing.
    if ($urandom_range(24) == 0) d.form = x86enc_pkg::FORM_NONE;
    else d.form = x86enc_pkg::form_t'($urandom_range(2));
    d.size      = x86enc_pkg::size_t'($urandom_range(3));
    d.opcode    = 8'($urandom_range(255));
    d.direction = 1'($urandom_range(1));
    d.amode     = x86enc_pkg::amode_t'($urandom_range(3));
    d.src_reg   = 3'($urandom_range(7));
    d.dst_reg   = 3'($urandom_range(7));
    d.scale     = 2'($urandom_range(3));
    d.index_reg = 3'($urandom_range(7));
    d.disp      = pick_operand();
    d.imm       = pick_operand();
    return d;
  endfunction

  // Driver. At each edge it first records an item taken by the block, then
  // decides what the channel carries next. valid gets at most one
  // nonblocking assignment per edge, so back-to-back items keep it high.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_encoding(cur_instr);
        accepted_count++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_instrs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_instr = pending_instrs.pop_front();
          in_ch.valid        <= 1'b1;
          in_ch.operation    <= cur_instr.form;
          in_ch.op_size      <= cur_instr.size;
          in_ch.opcode       <= cur_instr.opcode;
          in_ch.direction    <= cur_instr.direction;
          in_ch.addr_mode    <= cur_instr.amode;
          in_ch.src_reg      <= cur_instr.src_reg;
          in_ch.dst_reg      <= cur_instr.dst_reg;
          in_ch.sib_scale    <= cur_instr.scale;
          in_ch.index_reg    <= cur_instr.index_reg;
          in_ch.displacement <= cur_instr.disp;
          in_ch.imm_value    <= cur_instr.imm;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor. Every byte the block hands over is checked against the oldest
  // byte still owed, field by field; the receiver stalls at random.
  always @(posedge clk) begin : byte_monitor
    code_byte_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_bytes.size() == 0) begin
          $error("out_byte: no byte expected, got 0x%02h (last %0b)",
                 out_ch.out_byte, out_ch.last);
          error_count++;
        end else begin
          want = expected_bytes.pop_front();
          if (out_ch.out_byte !== want.value) begin
            $error("out_byte: expected 0x%02h, got 0x%02h", want.value, out_ch.out_byte);
            error_count++;
          end
          if (out_ch.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_ch.last);
            error_count++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog against a hung block.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL x86_instruction_byte_encoder");
      $finish;
    end
  end

  // Stimulus and end of run. The phases step through the idling patterns:
  // none, a mostly idle sender, a mostly stalling receiver, and both.
  initial begin
    int unsigned send_pcts[4];
    int unsigned recv_pcts[4];
    int unsigned phase;
    int unsigned n;
    send_pcts = '{0, 74, 0, 22};
    recv_pcts = '{0, 0, 74, 22};

    // Every input of the block is known from time zero.
    in_ch.valid        = 1'b0;
    in_ch.operation    = '0;
    in_ch.op_size      = '0;
    in_ch.opcode       = '0;
    in_ch.direction    = 1'b0;
    in_ch.addr_mode    = '0;
    in_ch.src_reg      = '0;
    in_ch.dst_reg      = '0;
    in_ch.sib_scale    = '0;
    in_ch.index_reg    = '0;
    in_ch.displacement = '0;
    in_ch.imm_value    = '0;
    out_ch.ready       = 1'b0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed items: both ends of each field, every form, every size code
    // and address mode, and the displacement and immediate boundaries.
    // Simple form, with and without the prefix, and the reserved size.
    pending_instrs.push_back(make_instr(x86enc_pkg::FORM_SIMPLE, x86enc_pkg::SZ_8, 8'h00, 0,
                                        x86enc_pkg::AM_REG, 0, 0, 0, 0, 0, 0));
    pending_instrs.push_back(make_instr(x86enc_pkg::FORM_SIMPLE, x86enc_pkg::SZ_16, 8'hff, 1,
                                        x86enc_pkg::AM_NONE, 7, 7, 3, 7,
                                        32'hffff_ffff, 32'hffff_ffff));
    pending_instrs.push_back(make_instr(x86enc_pkg::FORM_SIMPLE, x86enc_pkg::SZ_RSV, 8'h90, 0,
                                        x86enc_pkg::AM_SIB, 1, 2, 1, 3, 5, 6));
    // The unused form code produces no bytes, also with a sixteen-bit size.
    pending_instrs.push_back(make_instr(x86enc_pkg::FORM_NONE, x86enc_pkg::SZ_32, 8'h01, 1,
                                        x86enc_pkg::AM_REG, 1, 1, 1, 1, 1, 1));
    pending_instrs.push_back(make_instr(x86enc_pkg::FORM_NONE, x86enc_pkg::SZ_16, 8'hff, 0,
                                        x86enc_pkg::AM_SIB, 7, 7, 3, 7,
                                        32'h100, 32'h100));
    // Binary form in register mode, both directions, registers 0 and 7.
    pending_instrs.push_back(make_instr(x86enc_pkg::FORM_BINARY, x86enc_pkg::SZ_8, 8'h00, 0,
                                        x86enc_pkg::AM_REG, 0, 0, 0, 0, 0, 0));
    pending_instrs.push_back(make_instr(x86enc_pkg::FORM_BINARY, x86enc_pkg::SZ_16, 8'hfc, 1,
                                        x86enc_pkg::AM_REG, 7, 7, 0, 0, 0, 0));
    // Pointer mode across the displacement boundaries.
    pending_instrs.push_back(make_instr(x86enc_pkg::FORM_BINARY, x86enc_pkg::SZ_32, 8'h88, 0,
                                        x86enc_pkg::AM_PTR, 3, 5, 0, 0, 0, 0));
    pending_instrs.push_back(make_instr(x86enc_pkg::FORM_BINARY, x86enc_pkg::SZ_RSV, 8'h00, 1,
                                        x86enc_pkg::AM_PTR, 1, 2, 0, 0, 1, 0));
    pending_instrs.push_back(make_instr(x86enc_pkg::FORM_BINARY, x86enc_pkg::SZ_8, 8'h30, 0,
                                        x86enc_pkg::AM_PTR, 6, 4, 0, 0, 32'hff, 0));
    pending_instrs.push_back(make_instr(x86enc_pkg::FORM_BINARY, x86enc_pkg::SZ_16, 8'h8a, 1,
                                        x86enc_pkg::AM_PTR, 2, 6, 0, 0, 32'h100, 0));
    pending_instrs.push_back(make_instr(x86enc_pkg::FORM_BINARY, x86enc_pkg::SZ_32, 8'hfd, 0,
                                        x86enc_pkg::AM_PTR, 7, 7, 0, 0, 32'hffff_ffff, 0));
    // Scaled index mode, including the eight-byte worst case.
    pending_instrs.push_back(make_instr(x86enc_pkg::FORM_BINARY, x86enc_pkg::SZ_16, 8'h01, 1,
                                        x86enc_pkg::AM_SIB, 7, 7, 3, 7, 32'hffff_ffff, 0));
    pending_instrs.push_back(make_instr(x86enc_pkg::FORM_BINARY, x86enc_pkg::SZ_8, 8'h02, 0,
                                        x86enc_pkg::AM_SIB, 0, 0, 0, 0, 0, 0));
    pending_instrs.push_back(make_instr(x86enc_pkg::FORM_BINARY, x86enc_pkg::SZ_32, 8'h38, 1,
                                        x86enc_pkg::AM_SIB, 3, 5, 2, 4, 32'h80, 0));
    // The unused address mode keeps only opcode and displacement.
    pending_instrs.push_back(make_instr(x86enc_pkg::FORM_BINARY, x86enc_pkg::SZ_8, 8'h84, 0,
                                        x86enc_pkg::AM_NONE, 5, 3, 1, 2, 0, 0));
    pending_instrs.push_back(make_instr(x86enc_pkg::FORM_BINARY, x86enc_pkg::SZ_RSV, 8'h84, 1,
                                        x86enc_pkg::AM_NONE, 5, 3, 1, 2, 32'h1234_5678, 0));
    // Immediate form across the immediate boundaries and all address modes.
    pending_instrs.push_back(make_instr(x86enc_pkg::FORM_IMM, x86enc_pkg::SZ_8, 8'h07, 0,
                                        x86enc_pkg::AM_REG, 0, 0, 0, 0, 0, 0));
    pending_instrs.push_back(make_instr(x86enc_pkg::FORM_IMM, x86enc_pkg::SZ_16, 8'hf8, 1,
                                        x86enc_pkg::AM_REG, 7, 7, 0, 0, 0, 32'hff));
    pending_instrs.push_back(make_instr(x86enc_pkg::FORM_IMM, x86enc_pkg::SZ_32, 8'h05, 0,
                                        x86enc_pkg::AM_REG, 3, 2, 0, 0, 0, 32'h100));
    pending_instrs.push_back(make_instr(x86enc_pkg::FORM_IMM, x86enc_pkg::SZ_16, 8'hff, 1,
                                        x86enc_pkg::AM_SIB, 7, 7, 3, 7,
                                        32'hffff_ffff, 32'hffff_ffff));
    // Pointer and unused modes in the immediate form: no ModRM, no displacement.
    pending_instrs.push_back(make_instr(x86enc_pkg::FORM_IMM, x86enc_pkg::SZ_RSV, 8'h02, 0,
                                        x86enc_pkg::AM_PTR, 4, 1, 2, 2, 32'h55, 32'h10));
    pending_instrs.push_back(make_instr(x86enc_pkg::FORM_IMM, x86enc_pkg::SZ_8, 8'h06, 1,
                                        x86enc_pkg::AM_NONE, 1, 6, 1, 1,
                                        32'h100, 32'h1234));
    queued_count = pending_instrs.size();

    for (phase = 0; phase < 4; phase++) begin
      send_idle_pct  = send_pcts[phase];
      recv_stall_pct = recv_pcts[phase];
      for (n = 0; n < RANDOM_PER_PHASE; n++) begin
        pending_instrs.push_back(random_instr());
        queued_count++;
      end
      // Move to the next idling pattern once this phase's items are taken.
      while (accepted_count < queued_count) @(posedge clk);
    end

    // Every byte owed must arrive, then a short window catches stray bytes.
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("PASS x86_instruction_byte_encoder");
    end else begin
      $display("FAIL x86_instruction_byte_encoder");
    end
    $finish;
  end

endmodule

### sim.f
hdl/x86enc_pkg.sv
hdl/x86enc_if.sv
hdl/x86enc_front.sv
hdl/x86enc_queue.sv
hdl/x86enc_back.sv
hdl/x86_instruction_byte_encoder.sv
tb/sv/x86_instruction_byte_encoder_tb.sv
